/* design/led_dimmer_fade_controller_macros.svh */
// assertion macros for the led dimmer fade controller checker
// expects clk and rst_n in the scope where a macro is used
`ifndef LED_DIMMER_FADE_CONTROLLER_MACROS_SVH
`define LED_DIMMER_FADE_CONTROLLER_MACROS_SVH

// same-cycle implication, off during reset
`define LDF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ldf assertion failed");

// next-cycle implication, off during reset
`define LDF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ldf assertion failed");

`endif

/* design/ldf_pkg.sv */
// shared types, constants and register indexes for the led dimmer fade controller
// no dependencies
`default_nettype none

package ldf_pkg;

    localparam int LEVEL_BITS_DEF = 8;
    localparam int TIME_W         = 32;
    localparam int STEP_W         = 8;
    localparam int MS_W           = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    localparam logic [MS_W-1:0]   LONG_PRESS_RST   = 16'd1000;
    localparam logic [MS_W-1:0]   FRAME_PERIOD_RST = 16'd10;
    localparam logic [STEP_W-1:0] FADE_STEP_RST    = 8'd4;
    localparam logic [STEP_W-1:0] SETUP_STEP_RST   = 8'd1;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETUP_STEP   = 2'd3;

    typedef enum logic [1:0] {
        CMD_PRESS   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_HELD    = 2'd2,
        CMD_TICK    = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [MS_W-1:0]   long_press_ms;
        logic [MS_W-1:0]   frame_period_ms;
        logic [STEP_W-1:0] fade_step;
        logic [STEP_W-1:0] setup_step;
    } cfg_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [TIME_W-1:0] now_ms;
    } evt_t;

endpackage

`default_nettype wire

/* design/ldf_if.sv */
// request channels of the led dimmer fade controller: event, result and config write
// depends on ldf_pkg
`default_nettype none

interface ldf_event_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic [ldf_pkg::TIME_W-1:0]    now_ms;

    modport source (output valid, command, now_ms, input ready);
    modport sink   (input valid, command, now_ms, output ready);
endinterface

interface ldf_result_if #(
    parameter int LEVEL_BITS = ldf_pkg::LEVEL_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS-1:0] level;
    logic                  level_written;
    logic                  lamp_on;
    logic                  setup_active;

    modport source (output valid, level, level_written, lamp_on, setup_active, input ready);
    modport sink   (input valid, level, level_written, lamp_on, setup_active, output ready);
endinterface

interface ldf_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ldf_pkg::CFG_IDX_W-1:0]     index;
    logic [ldf_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/ldf_cfg.sv */
// configuration register file of the led dimmer fade controller
// depends on ldf_pkg
`default_nettype none

module ldf_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [ldf_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [ldf_pkg::CFG_DATA_W-1:0] wr_data,
    output ldf_pkg::cfg_t                       cfg
);

    ldf_pkg::cfg_t cfg_reg;
    ldf_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                ldf_pkg::REG_LONG_PRESS:
                    cfg_next.long_press_ms = wr_data[ldf_pkg::MS_W-1:0];
                ldf_pkg::REG_FRAME_PERIOD:
                    cfg_next.frame_period_ms = wr_data[ldf_pkg::MS_W-1:0];
                ldf_pkg::REG_FADE_STEP:
                    cfg_next.fade_step = wr_data[ldf_pkg::STEP_W-1:0];
                ldf_pkg::REG_SETUP_STEP:
                    cfg_next.setup_step = wr_data[ldf_pkg::STEP_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ms   <= ldf_pkg::LONG_PRESS_RST;
            cfg_reg.frame_period_ms <= ldf_pkg::FRAME_PERIOD_RST;
            cfg_reg.fade_step       <= ldf_pkg::FADE_STEP_RST;
            cfg_reg.setup_step      <= ldf_pkg::SETUP_STEP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* design/ldf_in_stage.sv */
// input register of the led dimmer fade controller
// depends on ldf_pkg
`default_nettype none

module ldf_in_stage (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  in_command,
    input  wire logic [ldf_pkg::TIME_W-1:0]  in_now_ms,
    input  wire logic                        advance,
    output logic                             evt_valid,
    output ldf_pkg::evt_t                    evt
);

    logic          valid_reg;
    logic          valid_next;
    ldf_pkg::evt_t evt_reg;
    logic          take;

    assign in_ready = !valid_reg || advance;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload only
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            evt_reg.cmd    <= ldf_pkg::cmd_t'(in_command);
            evt_reg.now_ms <= in_now_ms;
        end
    end

    assign evt_valid = valid_reg;
    assign evt       = evt_reg;

endmodule

`default_nettype wire

/* design/ldf_core.sv */
// dimmer state update and result register of the led dimmer fade controller
// depends on ldf_pkg
`default_nettype none

module ldf_core #(
    parameter int LEVEL_BITS = ldf_pkg::LEVEL_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          evt_valid,
    input  wire ldf_pkg::evt_t evt,
    input  wire ldf_pkg::cfg_t cfg,
    output logic               advance,
    output logic               res_valid,
    input  wire logic          res_ready,
    output logic [LEVEL_BITS-1:0] level,
    output logic               level_written,
    output logic               lamp_on,
    output logic               setup_active
);

    localparam int SUM_W = ((LEVEL_BITS > ldf_pkg::STEP_W) ? LEVEL_BITS : ldf_pkg::STEP_W) + 1;
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};

    logic                        res_valid_reg, res_valid_next;
    logic                        on_reg, on_next;
    logic                        setup_reg, setup_next;
    logic [LEVEL_BITS-1:0]       max_reg, max_next;
    logic [LEVEL_BITS-1:0]       cur_reg, cur_next;
    logic [LEVEL_BITS-1:0]       target_reg, target_next;
    logic [ldf_pkg::STEP_W-1:0]  mag_reg, mag_next;
    logic                        down_reg, down_next;
    logic [ldf_pkg::TIME_W-1:0]  press_reg, press_next;
    logic [ldf_pkg::TIME_W-1:0]  frame_reg, frame_next;
    logic                        wrote_reg, wrote_next;

    logic                        step_en;
    logic [ldf_pkg::TIME_W-1:0]  hold_deadline;
    logic [ldf_pkg::TIME_W-1:0]  frame_due;
    logic [SUM_W-1:0]            sum_up;
    logic [SUM_W-1:0]            floor_sum;
    logic [SUM_W-1:0]            diff_down;

    assign advance = !res_valid_reg || res_ready;
    assign step_en = evt_valid && advance;

    assign hold_deadline = press_reg + ldf_pkg::TIME_W'(cfg.long_press_ms);
    assign frame_due     = frame_reg + ldf_pkg::TIME_W'(cfg.frame_period_ms);
    assign sum_up        = SUM_W'(cur_reg) + SUM_W'(mag_reg);
    assign floor_sum     = SUM_W'(target_reg) + SUM_W'(mag_reg);
    assign diff_down     = SUM_W'(cur_reg) - SUM_W'(mag_reg);

    always_comb
    begin
        res_valid_next = res_valid_reg;
        on_next        = on_reg;
        setup_next     = setup_reg;
        max_next       = max_reg;
        cur_next       = cur_reg;
        target_next    = target_reg;
        mag_next       = mag_reg;
        down_next      = down_reg;
        press_next     = press_reg;
        frame_next     = frame_reg;
        wrote_next     = wrote_reg;

        if (advance)
            res_valid_next = evt_valid;

        if (step_en)
        begin
            wrote_next = 1'b0;
            case (evt.cmd)
                ldf_pkg::CMD_PRESS:
                begin
                    press_next = evt.now_ms;
                    mag_next   = cfg.fade_step;
                    if (on_reg)
                    begin
                        on_next     = 1'b0;
                        target_next = '0;
                        down_next   = 1'b1;
                    end
                    else
                    begin
                        on_next     = 1'b1;
                        target_next = max_reg;
                        down_next   = 1'b0;
                    end
                end
                ldf_pkg::CMD_RELEASE:
                begin
                    press_next = '0;
                    if (setup_reg)
                    begin
                        setup_next = 1'b0;
                        max_next   = cur_reg;
                        mag_next   = '0;
                    end
                end
                ldf_pkg::CMD_HELD:
                begin
                    if (!setup_reg && (hold_deadline < evt.now_ms))
                    begin
                        setup_next = 1'b1;
                        mag_next   = cfg.setup_step;
                        if (cur_reg == '0)
                        begin
                            down_next   = 1'b0;
                            target_next = LEVEL_MAX;
                        end
                        else
                        begin
                            down_next   = 1'b1;
                            target_next = '0;
                        end
                    end
                end
                ldf_pkg::CMD_TICK:
                begin
                    if (!(frame_due > evt.now_ms))
                    begin
                        frame_next = evt.now_ms;
                        if (mag_reg != '0)
                        begin
                            wrote_next = 1'b1;
                            if (!down_reg)
                            begin
                                if (sum_up > SUM_W'(target_reg))
                                begin
                                    cur_next = target_reg;
                                    if (setup_reg)
                                    begin
                                        down_next   = 1'b1;
                                        target_next = '0;
                                    end
                                    else
                                        mag_next = '0;
                                end
                                else
                                    cur_next = sum_up[LEVEL_BITS-1:0];
                            end
                            else
                            begin
                                if (SUM_W'(cur_reg) < floor_sum)
                                begin
                                    cur_next = target_reg;
                                    if (setup_reg)
                                    begin
                                        down_next   = 1'b0;
                                        target_next = LEVEL_MAX;
                                    end
                                    else
                                        mag_next = '0;
                                end
                                else
                                    cur_next = diff_down[LEVEL_BITS-1:0];
                            end
                        end
                    end
                end
                default:
                    wrote_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            on_reg        <= 1'b0;
            setup_reg     <= 1'b0;
            max_reg       <= LEVEL_MAX;
            cur_reg       <= '0;
            target_reg    <= '0;
            mag_reg       <= '0;
            down_reg      <= 1'b0;
            press_reg     <= '0;
            frame_reg     <= '0;
            wrote_reg     <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            on_reg        <= on_next;
            setup_reg     <= setup_next;
            max_reg       <= max_next;
            cur_reg       <= cur_next;
            target_reg    <= target_next;
            mag_reg       <= mag_next;
            down_reg      <= down_next;
            press_reg     <= press_next;
            frame_reg     <= frame_next;
            wrote_reg     <= wrote_next;
        end
    end

    assign res_valid     = res_valid_reg;
    assign level         = cur_reg;
    assign level_written = wrote_reg;
    assign lamp_on       = on_reg;
    assign setup_active  = setup_reg;

endmodule

`default_nettype wire

/* design/led_dimmer_fade_controller.sv */
// top level of the led dimmer fade controller
// depends on ldf_pkg, ldf_if, ldf_cfg, ldf_in_stage and ldf_core
//
// Takes one button or frame-tick event per clock unless the result is stalled, and
// returns exactly one result per event. An accepted event is held in the input
// register; the core then updates the dimmer state and loads the result register,
// so each event passes the input register and then the result register. The rate is
// set by the state update, which feeds back on itself from one event to the next.
// The result register holds a stalled result while the input register still takes one
// more event. The configuration port is always ready and should only be written while
// no event is in flight.
`default_nettype none

module led_dimmer_fade_controller #(
    parameter int LEVEL_BITS = ldf_pkg::LEVEL_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ldf_event_if.sink     evt,
    ldf_result_if.source  res,
    ldf_cfg_if.sink       cfg
);

    ldf_pkg::cfg_t         cfg_q;
    ldf_pkg::evt_t         evt_q;
    logic                  evt_q_valid;
    logic                  advance;
    logic [LEVEL_BITS-1:0] level;

    assign cfg.ready = 1'b1;

    ldf_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_q)
    );

    ldf_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (evt.valid),
        .in_ready   (evt.ready),
        .in_command (evt.command),
        .in_now_ms  (evt.now_ms),
        .advance    (advance),
        .evt_valid  (evt_q_valid),
        .evt        (evt_q)
    );

    ldf_core #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .evt_valid     (evt_q_valid),
        .evt           (evt_q),
        .cfg           (cfg_q),
        .advance       (advance),
        .res_valid     (res.valid),
        .res_ready     (res.ready),
        .level         (level),
        .level_written (res.level_written),
        .lamp_on       (res.lamp_on),
        .setup_active  (res.setup_active)
    );

    assign res.level = level;

endmodule

`default_nettype wire

/* design/ldf_checker.sv */
// port-level checks of the led dimmer fade controller, bound to the top level
// depends on led_dimmer_fade_controller_macros.svh and ldf_pkg
`default_nettype none

`include "led_dimmer_fade_controller_macros.svh"

module ldf_checker #(
    parameter int LEVEL_BITS = ldf_pkg::LEVEL_BITS_DEF
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  evt_valid,
    input wire logic                  evt_ready,
    input wire logic                  res_valid,
    input wire logic                  res_ready,
    input wire logic [LEVEL_BITS-1:0] res_level,
    input wire logic                  res_level_written,
    input wire logic                  res_lamp_on,
    input wire logic                  res_setup_active
);

    // stalled result stays put
    `LDF_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable({res_level, res_level_written, res_lamp_on, res_setup_active}))

    // a fresh result comes from a taken request that has passed the input register and the result register
    `LDF_ASSERT_NOW(a_res_origin, $rose(res_valid), $past(evt_valid && evt_ready, 2))

    // an empty output never blocks requests
    `LDF_ASSERT_NOW(a_ready_when_empty, !res_valid, evt_ready)

endmodule

bind led_dimmer_fade_controller ldf_checker #(
    .LEVEL_BITS (LEVEL_BITS)
) u_ldf_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .evt_valid         (evt.valid),
    .evt_ready         (evt.ready),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .res_level         (res.level),
    .res_level_written (res.level_written),
    .res_lamp_on       (res.lamp_on),
    .res_setup_active  (res.setup_active)
);

`default_nettype wire

/* test/led_dimmer_fade_controller_checker.sv */
// checker for the led dimmer fade controller: follows register writes and events,
// predicts each result and compares it with what the block returns
// depends on ldf_pkg and ldf_if
`default_nettype none

module led_dimmer_fade_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    ldf_event_if  evt,
    ldf_result_if res,
    ldf_cfg_if    cfg,
    output int    fail_count,
    output int    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ldf_pkg::*;

    localparam logic [7:0] LEVEL_TOP = 8'd255;

    typedef struct packed {
        logic [7:0] level;
        logic       written;
        logic       lamp;
        logic       setup;
    } dim_out_t;

    logic [MS_W-1:0]    hold_ms_r    = LONG_PRESS_RST;
    logic [MS_W-1:0]    frame_ms_r   = FRAME_PERIOD_RST;
    logic [STEP_W-1:0]  fade_step_r  = FADE_STEP_RST;
    logic [STEP_W-1:0]  sweep_step_r = SETUP_STEP_RST;

    logic               lamp_st      = 1'b0;
    logic [7:0]         ceiling_st   = LEVEL_TOP;
    logic signed [8:0]  ramp_st      = '0;
    logic [7:0]         bright_st    = '0;
    logic [7:0]         aim_st       = '0;
    logic               sweep_st     = 1'b0;
    logic [TIME_W-1:0]  pressed_at   = '0;
    logic [TIME_W-1:0]  last_frame   = '0;

    dim_out_t           expected_results[$];
    dim_out_t           want;
    dim_out_t           got;
    dim_out_t           fresh;

    initial fail_count = 0;
    assign pending = expected_results.size();

    task automatic advance_dimmer(input cmd_t c, input logic [TIME_W-1:0] now,
                                  output dim_out_t r);
        logic [TIME_W-1:0] due;
        int                sum;
        r.written = 1'b0;
        case (c)
            CMD_PRESS:
            begin
                pressed_at = now;
                if (lamp_st)
                begin
                    lamp_st = 1'b0;
                    aim_st  = '0;
                    ramp_st = 9'sd0 - $signed({1'b0, fade_step_r});
                end
                else
                begin
                    lamp_st = 1'b1;
                    aim_st  = ceiling_st;
                    ramp_st = $signed({1'b0, fade_step_r});
                end
            end
            CMD_RELEASE:
            begin
                pressed_at = '0;
                if (sweep_st)
                begin
                    sweep_st   = 1'b0;
                    ceiling_st = bright_st;
                    ramp_st    = '0;
                end
            end
            CMD_HELD:
            begin
                due = pressed_at + hold_ms_r;
                if (!sweep_st && due < now)
                begin
                    sweep_st = 1'b1;
                    if (bright_st == 8'd0)
                    begin
                        ramp_st = $signed({1'b0, sweep_step_r});
                        aim_st  = LEVEL_TOP;
                    end
                    else
                    begin
                        ramp_st = 9'sd0 - $signed({1'b0, sweep_step_r});
                        aim_st  = '0;
                    end
                end
            end
            default:
            begin
                due = last_frame + frame_ms_r;
                if (due <= now)
                begin
                    last_frame = now;
                    if (ramp_st != 9'sd0)
                    begin
                        r.written = 1'b1;
                        sum = int'(bright_st) + int'(ramp_st);
                        if (ramp_st > 9'sd0)
                        begin
                            if (sum > int'(aim_st))
                            begin
                                bright_st = aim_st;
                                if (sweep_st)
                                begin
                                    ramp_st = -ramp_st;
                                    aim_st  = '0;
                                end
                                else
                                    ramp_st = '0;
                            end
                            else
                                bright_st = sum[7:0];
                        end
                        else
                        begin
                            if (sum < int'(aim_st))
                            begin
                                bright_st = aim_st;
                                if (sweep_st)
                                begin
                                    ramp_st = -ramp_st;
                                    aim_st  = LEVEL_TOP;
                                end
                                else
                                    ramp_st = '0;
                            end
                            else
                                bright_st = sum[7:0];
                        end
                    end
                end
            end
        endcase
        r.level = bright_st;
        r.lamp  = lamp_st;
        r.setup = sweep_st;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ms_r    = LONG_PRESS_RST;
            frame_ms_r   = FRAME_PERIOD_RST;
            fade_step_r  = FADE_STEP_RST;
            sweep_step_r = SETUP_STEP_RST;
            lamp_st      = 1'b0;
            ceiling_st   = LEVEL_TOP;
            ramp_st      = '0;
            bright_st    = '0;
            aim_st       = '0;
            sweep_st     = 1'b0;
            pressed_at   = '0;
            last_frame   = '0;
            expected_results.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_LONG_PRESS:   hold_ms_r    = cfg.data;
                    REG_FRAME_PERIOD: frame_ms_r   = cfg.data;
                    REG_FADE_STEP:    fade_step_r  = cfg.data[STEP_W-1:0];
                    default:          sweep_step_r = cfg.data[STEP_W-1:0];
                endcase
            end
            if (res.valid && res.ready)
            begin
                got = '{res.level, res.level_written, res.lamp_on, res.setup_active};
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with no request pending: level %0d written %b lamp %b setup %b",
                             $time, got.level, got.written, got.lamp, got.setup);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected level %0d written %b lamp %b setup %b, actual level %0d written %b lamp %b setup %b",
                                 $time, want.level, want.written, want.lamp, want.setup,
                                 got.level, got.written, got.lamp, got.setup);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (evt.valid && evt.ready)
            begin
                advance_dimmer(cmd_t'(evt.command), evt.now_ms, fresh);
                expected_results.push_back(fresh);
            end
        end
    end

endmodule

`default_nettype wire

/* test/led_dimmer_fade_controller_tb.sv */
// testbench top for the led dimmer fade controller: clock, reset, event and register
// requests over several settings and idling patterns, verdict from the checker
// depends on ldf_pkg, ldf_if, the design and led_dimmer_fade_checker
`default_nettype none

module led_dimmer_fade_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ldf_pkg::*;

    localparam int QUIET_LIMIT = 4000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ldf_event_if  evt_ch ();
    ldf_result_if #(.LEVEL_BITS(8)) res_ch ();
    ldf_cfg_if    cfg_ch ();

    int           fail_count;
    int           pending;
    int           quiet_cycles = 0;
    int           src_idle_pct = 0;
    int           dst_stall_pct = 0;
    int           items_made = 0;

    evt_t              event_q[$];
    evt_t              next_evt;
    logic [TIME_W-1:0] t_ms = '0;
    logic [MS_W-1:0]   hold_ms = LONG_PRESS_RST;
    logic [MS_W-1:0]   frame_ms = FRAME_PERIOD_RST;

    led_dimmer_fade_controller #(.LEVEL_BITS(8)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    led_dimmer_fade_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt        (evt_ch),
        .res        (res_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!evt_ch.valid || evt_ch.ready)
        begin
            if (event_q.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                next_evt = event_q.pop_front();
                evt_ch.valid   <= 1'b1;
                evt_ch.command <= next_evt.cmd;
                evt_ch.now_ms  <= next_evt.now_ms;
            end
            else
                evt_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
        res_ch.ready <= ($urandom_range(99) >= dst_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[led_dimmer_fade_controller] ERROR");
                $finish;
            end
        end
    end

    task automatic add_evt(input cmd_t c, input logic [TIME_W-1:0] n);
        event_q.push_back('{c, n});
        items_made++;
    endtask

    task automatic add_ticks(input int n);
        repeat (n)
        begin
            t_ms = t_ms + 32'($urandom_range(0, 2 * int'(frame_ms) + 1));
            add_evt(CMD_TICK, t_ms);
        end
    endtask

    // press, fade, optional long hold with sweep, release; sometimes noise instead
    task automatic gen_scenario();
        int                roll;
        logic [TIME_W-1:0] press_t;
        roll = $urandom_range(99);
        if (roll < 70)
        begin
            t_ms = t_ms + 32'($urandom_range(0, 20));
            press_t = t_ms;
            add_evt(CMD_PRESS, t_ms);
            add_ticks($urandom_range(1, 12));
            if ($urandom_range(1))
            begin
                add_evt(CMD_HELD, t_ms);
                t_ms = press_t + hold_ms + 32'($urandom_range(0, 2));
                add_evt(CMD_HELD, t_ms);
                t_ms = t_ms + 32'd1;
                add_evt(CMD_HELD, t_ms);
                add_ticks($urandom_range(5, 40));
                if ($urandom_range(3) == 0)
                begin
                    add_evt(CMD_PRESS, t_ms);
                    add_ticks($urandom_range(2, 20));
                end
            end
            add_evt(CMD_RELEASE, t_ms);
            add_ticks($urandom_range(0, 8));
        end
        else if (roll < 85)
            add_ticks($urandom_range(1, 10));
        else
        begin
            if ($urandom_range(3) == 0)
                t_ms = $urandom();
            add_evt(cmd_t'($urandom_range(3)), $urandom());
        end
    endtask

    task automatic wait_idle();
        while (event_q.size() != 0 || evt_ch.valid || pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [MS_W-1:0] lp, input logic [MS_W-1:0] fp,
                             input logic [STEP_W-1:0] fs, input logic [STEP_W-1:0] ss,
                             input int src_pct, input int dst_pct, input int n,
                             input logic [TIME_W-1:0] start_t);
        int stop_at;
        wait_idle();
        write_reg(REG_LONG_PRESS, lp);
        write_reg(REG_FRAME_PERIOD, fp);
        write_reg(REG_FADE_STEP, (16'($urandom_range(65535)) & 16'hFF00) | fs);
        write_reg(REG_SETUP_STEP, (16'($urandom_range(65535)) & 16'hFF00) | ss);
        hold_ms = lp;
        frame_ms = fp;
        src_idle_pct = src_pct;
        dst_stall_pct = dst_pct;
        t_ms = start_t;
        stop_at = items_made + n;
        while (items_made < stop_at)
            gen_scenario();
    endtask

    initial
    begin
        evt_ch.valid   = 1'b0;
        evt_ch.command = CMD_PRESS;
        evt_ch.now_ms  = '0;
        res_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = REG_LONG_PRESS;
        cfg_ch.data    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests at reset settings
        add_evt(CMD_PRESS,   32'd0);
        add_evt(CMD_TICK,    32'd5);
        add_evt(CMD_TICK,    32'd10);
        add_evt(CMD_TICK,    32'd10);
        add_evt(CMD_TICK,    32'd20);
        add_evt(CMD_HELD,    32'd500);
        add_evt(CMD_HELD,    32'd1000);
        add_evt(CMD_HELD,    32'd1001);
        add_evt(CMD_HELD,    32'd2000);
        add_evt(CMD_TICK,    32'd2000);
        add_evt(CMD_PRESS,   32'd2005);
        add_evt(CMD_TICK,    32'd2100);
        add_evt(CMD_TICK,    32'd2200);
        add_evt(CMD_RELEASE, 32'd2300);
        add_evt(CMD_RELEASE, 32'd2400);
        add_evt(CMD_PRESS,   32'hFFFF_FFF0);
        add_evt(CMD_TICK,    32'hFFFF_FFFF);
        add_evt(CMD_HELD,    32'hFFFF_FFFF);
        add_evt(CMD_TICK,    32'd0);
        add_evt(CMD_TICK,    32'd9);
        add_evt(CMD_TICK,    32'h7FFF_FFFF);
        add_evt(CMD_RELEASE, 32'd0);
        add_evt(CMD_PRESS,   32'hAAAA_5555);

        run_phase(16'd20,    16'd2,     8'd4,   8'd9,   0,  0,  150, 32'd0);
        run_phase(16'd0,     16'd0,     8'd255, 8'd255, 87, 0,  120, 32'd100);
        run_phase(16'd65535, 16'd65535, 8'd1,   8'd1,   0,  87, 80,  32'd0);
        run_phase(16'd7,     16'd1,     8'd0,   8'd0,   7,  7,  80,  32'd5000);
        run_phase(16'd30,    16'd3,     8'd17,  8'd50,  0,  0,  150, 32'hFFFF_FF00);
        run_phase(16'd300,   16'd10,    8'd64,  8'd128, 87, 0,  120, 32'h8000_0000);
        run_phase(16'd5,     16'd0,     8'd3,   8'd255, 0,  87, 150, 32'd77);

        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("[led_dimmer_fade_controller] OK");
        else
            $display("[led_dimmer_fade_controller] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+design
design/ldf_pkg.sv
design/ldf_if.sv
design/ldf_cfg.sv
design/ldf_in_stage.sv
design/ldf_core.sv
design/led_dimmer_fade_controller.sv
design/ldf_checker.sv
test/led_dimmer_fade_controller_checker.sv
test/led_dimmer_fade_controller_tb.sv
